// ===== src/mvn_pkg.sv =====
`default_nettype none

package mvn_pkg;

	// defaults for the top level parameters
	localparam int unsigned DEF_MAX_VERTICES = 1024;
	localparam int unsigned DEF_COORD_BITS   = 16;

	// fixed field widths
	localparam int unsigned IDX_W = 10;
	localparam int unsigned OUT_W = 16;
	localparam int unsigned SUM_W = 24;
	localparam int unsigned NV_W  = 36;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_TRI  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [OUT_W-1:0]   pos_x;
		logic signed [OUT_W-1:0]   pos_y;
		logic signed [OUT_W-1:0]   pos_z;
		logic [IDX_W-1:0]          corner_a;
		logic [IDX_W-1:0]          corner_b;
		logic [IDX_W-1:0]          corner_c;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]          out_index;
		logic signed [OUT_W-1:0]   norm_x;
		logic signed [OUT_W-1:0]   norm_y;
		logic signed [OUT_W-1:0]   norm_z;
		logic                      zero_sum;
	} rsp_t;

	// request into the normalize unit
	typedef struct packed {
		logic                      start;
		logic signed [NV_W-1:0]    vx;
		logic signed [NV_W-1:0]    vy;
		logic signed [NV_W-1:0]    vz;
	} norm_req_t;

	// answer from the normalize unit
	typedef struct packed {
		logic                      done;
		logic                      zero;
		logic signed [OUT_W-1:0]   nx;
		logic signed [OUT_W-1:0]   ny;
		logic signed [OUT_W-1:0]   nz;
	} norm_rsp_t;

	// saturating add of a unit component to a sum component
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
			input logic [OUT_W-1:0] n);
		logic signed [SUM_W:0] t;
		t = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-OUT_W){n[OUT_W-1]}}, n});
		if (t[SUM_W] != t[SUM_W-1]) begin
			sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = t[SUM_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/mvn_ram.sv =====
`default_nettype none

module mvn_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, read first, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== src/mvn_norm.sv =====
`default_nettype none

module mvn_norm
	import mvn_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire norm_req_t req,
	output norm_rsp_t      rsp
);

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_SQRT  = 6'b001000,
		N_DIV   = 6'b010000,
		N_DONE  = 6'b100000
	} nstate_t;

	nstate_t            st_q;
	logic [NV_W-1:0]    m_q [3];
	logic [2:0]         neg_q;
	logic [NV_W-1:0]    mx_q;
	logic [63:0]        acc_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [31:0]        rem_q;
	logic [16:0]        quo_q;
	logic [16:0]        nb_q;
	logic [4:0]         cnt_q;
	logic [1:0]         comp_q;
	logic [OUT_W-1:0]   o_q [3];
	logic               zero_q;

	// magnitudes and largest one at start
	logic [NV_W-1:0] ma, mb, mc, mx;
	always_comb begin
		ma = req.vx[NV_W-1] ? NV_W'(-req.vx) : NV_W'(req.vx);
		mb = req.vy[NV_W-1] ? NV_W'(-req.vy) : NV_W'(req.vy);
		mc = req.vz[NV_W-1] ? NV_W'(-req.vz) : NV_W'(req.vz);
		mx = ma;
		if (mb > mx) mx = mb;
		if (mc > mx) mx = mc;
	end

	// one square per cycle, one root bit per cycle, one quotient bit per cycle
	logic [59:0] sq;
	logic [63:0] sq_t;
	logic [32:0] r2;
	logic        qb;
	logic [32:0] r2_sub;
	logic [16:0] qfull;
	logic [17:0] qr;
	logic [OUT_W-1:0] qv;
	always_comb begin
		sq     = m_q[0][29:0] * m_q[0][29:0];
		sq_t   = root_q + bit_q;
		r2     = {rem_q, nb_q[16]};
		qb     = (r2 >= {1'b0, root_q[31:0]});
		r2_sub = r2 - {1'b0, root_q[31:0]};
		qfull  = {quo_q[15:0], qb};
		qr     = (18'(qfull) + 18'd1) >> 1;
		if (qr > 18'd16384) begin
			qv = OUT_W'(16384);
		end else begin
			qv = qr[OUT_W-1:0];
		end
		if (neg_q[0]) begin
			qv = -qv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			unique case (st_q)
				N_IDLE: begin
					if (req.start) begin
						m_q[0] <= ma;
						m_q[1] <= mb;
						m_q[2] <= mc;
						neg_q  <= {req.vz[NV_W-1], req.vy[NV_W-1], req.vx[NV_W-1]};
						mx_q   <= mx;
						acc_q  <= '0;
						cnt_q  <= '0;
						if (mx == '0) begin
							zero_q <= 1'b1;
							o_q[0] <= '0;
							o_q[1] <= '0;
							o_q[2] <= '0;
							st_q   <= N_DONE;
						end else begin
							zero_q <= 1'b0;
							st_q   <= N_SHIFT;
						end
					end
				end
				// bring the largest magnitude into [2^29, 2^30)
				N_SHIFT: begin
					if (mx_q[NV_W-1:30] != '0) begin
						mx_q   <= mx_q >> 1;
						m_q[0] <= m_q[0] >> 1;
						m_q[1] <= m_q[1] >> 1;
						m_q[2] <= m_q[2] >> 1;
					end else if (!mx_q[29]) begin
						mx_q   <= mx_q << 1;
						m_q[0] <= m_q[0] << 1;
						m_q[1] <= m_q[1] << 1;
						m_q[2] <= m_q[2] << 1;
					end else begin
						st_q <= N_SQ;
					end
				end
				// sum of squares, components rotate through slot 0
				N_SQ: begin
					acc_q  <= acc_q + 64'(sq);
					m_q[0] <= m_q[1];
					m_q[1] <= m_q[2];
					m_q[2] <= m_q[0];
					if (cnt_q == 5'd2) begin
						cnt_q  <= '0;
						root_q <= '0;
						bit_q  <= 64'd1 << 62;
						st_q   <= N_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				// integer square root, two bits of the radicand per step
				N_SQRT: begin
					if (acc_q >= sq_t) begin
						acc_q  <= acc_q - sq_t;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == 5'd31) begin
						rem_q  <= 32'(m_q[0][29:2]);
						nb_q   <= {m_q[0][1:0], 15'd0};
						quo_q  <= '0;
						cnt_q  <= '0;
						comp_q <= '0;
						st_q   <= N_DIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				// restoring divide of (m << 15) by the length
				N_DIV: begin
					if (cnt_q == 5'd16) begin
						o_q[0] <= o_q[1];
						o_q[1] <= o_q[2];
						o_q[2] <= qv;
						m_q[0] <= m_q[1];
						m_q[1] <= m_q[2];
						m_q[2] <= m_q[0];
						neg_q  <= {neg_q[0], neg_q[2:1]};
						rem_q  <= 32'(m_q[1][29:2]);
						nb_q   <= {m_q[1][1:0], 15'd0};
						quo_q  <= '0;
						cnt_q  <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							st_q <= N_DONE;
						end
					end else begin
						rem_q <= qb ? r2_sub[31:0] : r2[31:0];
						quo_q <= qfull;
						nb_q  <= nb_q << 1;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_DONE: begin
					st_q <= N_IDLE;
				end
				default: begin
					st_q <= N_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (st_q == N_DONE);
	assign rsp.zero = zero_q;
	assign rsp.nx   = o_q[0];
	assign rsp.ny   = o_q[1];
	assign rsp.nz   = o_q[2];

endmodule

`default_nettype wire

// ===== src/mesh_vertex_normal_engine_top.sv =====
// Smooth per-vertex normals of a triangle mesh, Q2.14 fixed point.
// Command channel: a beat is taken at a clock edge with start high and busy
// low. Action 0 loads a vertex position and clears its normal sum. Action 1
// adds a triangle: three position reads, cross product, normalize, then,
// unless the normal is zero, a read-modify-write of each corner's sum.
// Action 2 reads one sum and normalizes it; its result follows. The
// normalize unit sets the length of both: it starts, shifts the vector into
// range, sums the squares, takes the square root and divides each component.
// Loads and ignored commands leave busy low.
// Result channel: rsp is valid for exactly one cycle with rsp_valid high and
// is taken at the edge that ends that cycle; the receiver cannot stall it.
// After reset the block runs a clearing pass over the normal sum memory, one
// entry a cycle, with busy high; the position memory is not cleared and must
// be loaded before a triangle uses a vertex.
`default_nettype none

module mesh_vertex_normal_engine_top
	import mvn_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int unsigned COORD_BITS   = DEF_COORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	output rsp_t      rsp
);

	localparam int unsigned AW    = $clog2(MAX_VERTICES);
	localparam int unsigned CW    = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int unsigned POS_W = 3 * CW;
	localparam int unsigned NS_W  = 3 * SUM_W;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_TRD   = 10'b0000000100,
		S_TCAP  = 10'b0000001000,
		S_CROSS = 10'b0000010000,
		S_TNRM  = 10'b0000100000,
		S_ARD   = 10'b0001000000,
		S_AWR   = 10'b0010000000,
		S_RWAIT = 10'b0100000000,
		S_RNRM  = 10'b1000000000
	} state_t;

	state_t            st_q;
	logic [AW-1:0]     clr_q;
	logic [1:0]        k_q;
	logic [AW-1:0]     ca_q, cb_q, cc_q;
	logic [IDX_W-1:0]  vi_q;
	logic [POS_W-1:0]  pa_q, pb_q, pc_q;
	logic signed [34:0] cr0_q, cr1_q, cr2_q;
	logic              tri_go_q;
	logic [OUT_W-1:0]  nx_q, ny_q, nz_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// memory ports
	logic              pos_we, sum_we;
	logic [AW-1:0]     pos_addr, sum_addr;
	logic [POS_W-1:0]  pos_wdata, pos_rdata;
	logic [NS_W-1:0]   sum_wdata, sum_rdata;

	norm_req_t nreq;
	norm_rsp_t nrsp;

	// range checks on the command indexes
	logic vi_ok, tri_ok;
	assign vi_ok  = ({22'd0, cmd.vertex_index} < 32'(MAX_VERTICES));
	assign tri_ok = ({22'd0, cmd.corner_a} < 32'(MAX_VERTICES))
		&& ({22'd0, cmd.corner_b} < 32'(MAX_VERTICES))
		&& ({22'd0, cmd.corner_c} < 32'(MAX_VERTICES));

	logic take;
	assign take = start && (st_q == S_IDLE);

	// corner selected by the step counter
	logic [AW-1:0] ck;
	always_comb begin
		unique case (k_q)
			2'd0:    ck = ca_q;
			2'd1:    ck = cb_q;
			default: ck = cc_q;
		endcase
	end

	// edges from the stored positions
	logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic signed [16:0]   ux, uy, uz, wx, wy, wz;
	assign {ax, ay, az} = pa_q;
	assign {bx, by, bz} = pb_q;
	assign {cx, cy, cz} = pc_q;
	assign ux = 17'(bx) - 17'(ax);
	assign uy = 17'(by) - 17'(ay);
	assign uz = 17'(bz) - 17'(az);
	assign wx = 17'(cx) - 17'(ax);
	assign wy = 17'(cy) - 17'(ay);
	assign wz = 17'(cz) - 17'(az);

	// one cross product component per cycle
	logic signed [16:0] o1a, o1b, o2a, o2b;
	logic signed [33:0] p1, p2;
	logic signed [34:0] crj;
	always_comb begin
		unique case (k_q)
			2'd0: begin
				o1a = uy; o1b = wz; o2a = uz; o2b = wy;
			end
			2'd1: begin
				o1a = uz; o1b = wx; o2a = ux; o2b = wz;
			end
			default: begin
				o1a = ux; o1b = wy; o2a = uy; o2b = wx;
			end
		endcase
		p1  = o1a * o1b;
		p2  = o2a * o2b;
		crj = 35'(p1) - 35'(p2);
	end

	// sums as read back
	logic [SUM_W-1:0] sx, sy, sz;
	assign {sx, sy, sz} = sum_rdata;

	// normalize requests: a read takes the sum straight from memory
	always_comb begin
		nreq.start = (st_q == S_RWAIT) || tri_go_q;
		if (st_q == S_RWAIT) begin
			nreq.vx = NV_W'($signed(sx));
			nreq.vy = NV_W'($signed(sy));
			nreq.vz = NV_W'($signed(sz));
		end else begin
			nreq.vx = NV_W'(cr0_q);
			nreq.vy = NV_W'(cr1_q);
			nreq.vz = NV_W'(cr2_q);
		end
	end

	// memory port muxing
	always_comb begin
		pos_we    = 1'b0;
		pos_addr  = AW'(cmd.vertex_index);
		pos_wdata = {cmd.pos_x[CW-1:0], cmd.pos_y[CW-1:0], cmd.pos_z[CW-1:0]};
		sum_we    = 1'b0;
		sum_addr  = AW'(cmd.vertex_index);
		sum_wdata = '0;
		priority case (1'b1)
			st_q == S_CLEAR: begin
				sum_we   = 1'b1;
				sum_addr = clr_q;
			end
			st_q == S_IDLE: begin
				pos_we = take && (cmd.action == ACT_LOAD) && vi_ok;
				sum_we = pos_we;
			end
			st_q == S_TRD: begin
				pos_addr = ck;
			end
			st_q == S_ARD: begin
				sum_addr = ck;
			end
			st_q == S_AWR: begin
				sum_addr  = ck;
				sum_we    = 1'b1;
				sum_wdata = {sat_add(sx, nx_q), sat_add(sy, ny_q), sat_add(sz, nz_q)};
			end
			default: begin
			end
		endcase
	end

	mvn_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.addr  (pos_addr),
		.wdata (pos_wdata),
		.rdata (pos_rdata)
	);

	mvn_ram #(.WIDTH(NS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.addr  (sum_addr),
		.wdata (sum_wdata),
		.rdata (sum_rdata)
	);

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.rsp    (nrsp)
	);

	// one-cycle strobes: normalize start for a triangle, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_go_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			tri_go_q    <= (st_q == S_CROSS) && (k_q == 2'd2);
			rsp_valid_q <= (take && (cmd.action == ACT_READ) && !vi_ok)
				|| ((st_q == S_RNRM) && nrsp.done);
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLEAR;
			clr_q <= '0;
			k_q   <= '0;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_VERTICES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						unique case (cmd.action)
							ACT_TRI: begin
								if (tri_ok) begin
									ca_q <= AW'(cmd.corner_a);
									cb_q <= AW'(cmd.corner_b);
									cc_q <= AW'(cmd.corner_c);
									k_q  <= '0;
									st_q <= S_TRD;
								end
							end
							ACT_READ: begin
								vi_q <= cmd.vertex_index;
								if (vi_ok) begin
									st_q <= S_RWAIT;
								end else begin
									rsp_q.out_index <= cmd.vertex_index;
									rsp_q.norm_x    <= '0;
									rsp_q.norm_y    <= '0;
									rsp_q.norm_z    <= '0;
									rsp_q.zero_sum  <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// issue three position reads, capture each in the cycle after its read
				S_TRD: begin
					if (k_q == 2'd1) pa_q <= pos_rdata;
					if (k_q == 2'd2) begin
						pb_q <= pos_rdata;
						st_q <= S_TCAP;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_TCAP: begin
					pc_q <= pos_rdata;
					k_q  <= '0;
					st_q <= S_CROSS;
				end
				S_CROSS: begin
					unique case (k_q)
						2'd0:    cr0_q <= crj;
						2'd1:    cr1_q <= crj;
						default: cr2_q <= crj;
					endcase
					if (k_q == 2'd2) begin
						st_q <= S_TNRM;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_TNRM: begin
					if (nrsp.done) begin
						nx_q <= nrsp.nx;
						ny_q <= nrsp.ny;
						nz_q <= nrsp.nz;
						k_q  <= '0;
						st_q <= nrsp.zero ? S_IDLE : S_ARD;
					end
				end
				// read-modify-write of each corner sum
				S_ARD: begin
					st_q <= S_AWR;
				end
				S_AWR: begin
					if (k_q == 2'd2) begin
						st_q <= S_IDLE;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= S_ARD;
					end
				end
				S_RWAIT: begin
					st_q <= S_RNRM;
				end
				S_RNRM: begin
					if (nrsp.done) begin
						rsp_q.out_index <= vi_q;
						rsp_q.norm_x    <= nrsp.nx;
						rsp_q.norm_y    <= nrsp.ny;
						rsp_q.norm_z    <= nrsp.nz;
						rsp_q.zero_sum  <= nrsp.zero;
						st_q            <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (st_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
	import mvn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NVERT = 1024;
	localparam int SUM_HI = 8388607;
	localparam int SUM_LO = -8388608;

	// Vertex normal predictor: position store, saturating sums, expected reads
	class normal_board;
		longint pos[NVERT][3];
		longint sums[NVERT][3];
		rsp_t pending[$];
		int errors;

		function new();
			foreach (sums[i, j]) begin
				sums[i][j] = 0;
				pos[i][j] = 0;
			end
			errors = 0;
		endfunction

		static function longint root64(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// scale a vector to unit length in Q2.14; 0 when the vector is zero
		static function bit to_unit(input longint v[3], output longint o[3]);
			longint unsigned m[3], mx, sq, len, q;
			bit neg[3];
			mx = 0;
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = v[i] < 0;
				m[i] = neg[i] ? -v[i] : v[i];
				if (m[i] > mx) mx = m[i];
				o[i] = 0;
			end
			if (mx == 0) return 0;
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			while (mx < (64'd1 << 29)) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++) m[i] <<= 1;
			end
			for (int i = 0; i < 3; i++) sq += m[i] * m[i];
			len = root64(sq);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 15) / len + 1) >> 1;
				if (q > 16384) q = 16384;
				o[i] = neg[i] ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		function void note_cmd(cmd_t c);
			longint u[3], w[3], cr[3], n[3], r;
			int k[3];
			rsp_t e;
			unique case (c.action)
				ACT_LOAD: begin
					pos[c.vertex_index][0] = c.pos_x;
					pos[c.vertex_index][1] = c.pos_y;
					pos[c.vertex_index][2] = c.pos_z;
					for (int i = 0; i < 3; i++) sums[c.vertex_index][i] = 0;
				end
				ACT_TRI: begin
					k[0] = c.corner_a;
					k[1] = c.corner_b;
					k[2] = c.corner_c;
					for (int i = 0; i < 3; i++) begin
						u[i] = pos[k[1]][i] - pos[k[0]][i];
						w[i] = pos[k[2]][i] - pos[k[0]][i];
					end
					cr[0] = u[1] * w[2] - u[2] * w[1];
					cr[1] = u[2] * w[0] - u[0] * w[2];
					cr[2] = u[0] * w[1] - u[1] * w[0];
					if (to_unit(cr, n)) begin
						foreach (k[i])
							for (int j = 0; j < 3; j++) begin
								r = sums[k[i]][j] + n[j];
								if (r > SUM_HI) r = SUM_HI;
								if (r < SUM_LO) r = SUM_LO;
								sums[k[i]][j] = r;
							end
					end
				end
				ACT_READ: begin
					e.out_index = c.vertex_index;
					e.zero_sum = !to_unit(sums[c.vertex_index], n);
					e.norm_x = OUT_W'(n[0]);
					e.norm_y = OUT_W'(n[1]);
					e.norm_z = OUT_W'(n[2]);
					pending = {pending, e};
				end
				default: ;
			endcase
		endfunction

		task check_rsp(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report("normal read with nothing outstanding");
				return;
			end
			e = pending.pop_front();
			if (got.out_index != e.out_index)
				report($sformatf("out_index %0d want %0d", got.out_index, e.out_index));
			if (got.norm_x != e.norm_x)
				report($sformatf("v%0d norm_x %0d want %0d", e.out_index, got.norm_x, e.norm_x));
			if (got.norm_y != e.norm_y)
				report($sformatf("v%0d norm_y %0d want %0d", e.out_index, got.norm_y, e.norm_y));
			if (got.norm_z != e.norm_z)
				report($sformatf("v%0d norm_z %0d want %0d", e.out_index, got.norm_z, e.norm_z));
			if (got.zero_sum != e.zero_sum)
				report($sformatf("v%0d zero_sum %0b want %0b", e.out_index, got.zero_sum,
					e.zero_sum));
		endtask

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic rsp_valid;
	rsp_t rsp;

	normal_board board;
	int idle_pct;
	bit loaded[NVERT];
	int loaded_list[$];
	cmd_t spare_cmd;

	mesh_vertex_normal_engine_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// result side: every strobed beat is checked
	always @(posedge clk) begin
		if (arst_n && rsp_valid) board.check_rsp(rsp);
	end

	// send one command beat from a falling edge, with random sender idling
	// first; start stays up until the next beat or an idle cycle
	task automatic send(cmd_t c);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_cmd(c);
		@(negedge clk);
	endtask

	function automatic cmd_t noise();
		cmd_t c;
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		c = r[$bits(cmd_t)-1:0];
		return c;
	endfunction

	task automatic load(int v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		cmd_t c;
		c = noise();
		c.action = ACT_LOAD;
		c.vertex_index = IDX_W'(v);
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		send(c);
		if (!loaded[v]) begin
			loaded[v] = 1;
			loaded_list = {loaded_list, v};
		end
	endtask

	task automatic tri3(int a, int b, int cc);
		cmd_t c;
		c = noise();
		c.action = ACT_TRI;
		c.corner_a = IDX_W'(a);
		c.corner_b = IDX_W'(b);
		c.corner_c = IDX_W'(cc);
		send(c);
	endtask

	task automatic read_normal(int v);
		cmd_t c;
		c = noise();
		c.action = ACT_READ;
		c.vertex_index = IDX_W'(v);
		send(c);
	endtask

	function automatic int any_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	// one random command, mostly well-formed mesh traffic
	task automatic random_cmd();
		int r;
		cmd_t c;
		r = $urandom_range(99);
		if (r < 25 || loaded_list.size() < 3) begin
			if ($urandom_range(3) == 0 && loaded_list.size() > 0)
				load(any_loaded(), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				load($urandom_range(NVERT - 1), 16'($urandom), 16'($urandom),
					16'($urandom));
		end else if (r < 60) begin
			if ($urandom_range(9) == 0)
				tri3(any_loaded(), any_loaded(), any_loaded());
			else
				tri3(loaded_list[$urandom_range(loaded_list.size() - 1)],
					loaded_list[$urandom_range(loaded_list.size() - 1)],
					loaded_list[$urandom_range(loaded_list.size() - 1)]);
		end else if (r < 95) begin
			read_normal($urandom_range(2) == 0 ? $urandom_range(NVERT - 1) : any_loaded());
		end else begin
			c = noise();
			c.action = ACT_NONE;
			send(c);
		end
	endtask

	// stop sending until every expected read has come back
	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		#3000000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		idle_pct = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, saturation build-up, degenerate and unused cases
		read_normal(0);
		read_normal(1023);
		load(0, 16'h0000, 16'h0000, 16'h0000);
		load(1, 16'h4000, 16'h0000, 16'h0000);
		load(2, 16'h0000, 16'h4000, 16'h0000);
		load(1023, 16'h7fff, 16'h8000, 16'h7fff);
		load(3, 16'h8000, 16'h8000, 16'h8000);
		tri3(0, 1, 2);
		read_normal(0);
		tri3(0, 0, 2);
		tri3(0, 1, 1);
		tri3(1023, 3, 1);
		read_normal(1023);
		tri3(0, 2, 1);
		read_normal(1);
		load(4, 16'hffff, 16'h0001, 16'h7fff);
		for (int i = 0; i < 600; i++) tri3(0, 1, 2);
		read_normal(2);
		tri3(3, 4, 1023);
		read_normal(4);
		load(2, 16'h1234, 16'hedcb, 16'h0000);
		read_normal(2);
		spare_cmd = noise();
		spare_cmd.action = ACT_NONE;
		send(spare_cmd);
		drain();

		// random phases with differing sender idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 71 : (ph == 3) ? 7 : 0;
			for (int i = 0; i < 150; i++) begin
				random_cmd();
				if (i == 75) drain();
			end
			drain();
		end

		repeat (200) @(negedge clk);
		if (board.pending.size() == 0 && board.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/mvn_pkg.sv
src/mvn_ram.sv
src/mvn_norm.sv
src/mesh_vertex_normal_engine_top.sv
sim/testbench.sv
